>>> hdl/bocu_pkg.sv
// ----------------------------------------------------------------------------
// bocu_pkg
// shared types, constants and helpers for the branch opcode codec unit
// ----------------------------------------------------------------------------
package bocu_pkg;

    // operation selector carried on the input tuser
    typedef enum logic [2:0] {
        OP_RJMP_DEC  = 3'd0,
        OP_RJMP_ENC  = 3'd1,
        OP_JMP_ENC   = 3'd2,
        OP_JMP_DEC   = 3'd3,
        OP_CLASSIFY  = 3'd4
    } op_t;

    // register indexes on the apb port
    localparam logic REG_FLASH_SIZE_LOG2 = 1'b0;
    localparam logic REG_ADDRESS_MODE    = 1'b1;

    // register widths and reset values
    localparam int unsigned FSL_W = 5;
    localparam int unsigned AM_W  = 2;
    localparam logic [FSL_W-1:0] FSL_RESET = 5'd15;
    localparam logic [AM_W-1:0]  AM_RESET  = 2'd2;

    // field widths
    localparam int unsigned INSTR_W = 32;
    localparam int unsigned DIST_W  = 16;
    localparam int unsigned ADDR_W  = 23;
    localparam int unsigned CODE_W  = 32;
    localparam int unsigned DDIST_W = 13;

    // packed stream widths, padded to whole bytes
    localparam int unsigned IN_DATA_W  = 72;
    localparam int unsigned OUT_DATA_W = 72;
    localparam int unsigned OP_W       = 3;

    // opcode patterns
    localparam logic [15:0] RJMP_MASK   = 16'hf000;
    localparam logic [15:0] RJMP_BASE   = 16'hc000;
    localparam logic [15:0] JMP_BASE    = 16'h940c;
    localparam logic [15:0] CALL_BASE   = 16'h940e;
    localparam logic [15:0] LONGJ_MASK  = 16'hfe0e;
    localparam logic [15:0] LDST_MASK   = 16'hfe0f;
    localparam logic [15:0] STS_BASE    = 16'h9200;
    localparam logic [15:0] LDS_BASE    = 16'h9000;

    // largest relative wrap exponent (8192 bytes)
    localparam logic [FSL_W-1:0] WRAP_LG_MAX = 5'd13;
    localparam logic [FSL_W-1:0] WRAP_LG_MIN = 5'd1;

    // configuration handed from the register file to the datapath
    typedef struct packed {
        logic [FSL_W-1:0] flash_size_log2;
        logic [AM_W-1:0]  address_mode;
    } cfg_t;

    // result fields of one item
    typedef struct packed {
        logic                     is_abs_jump;
        logic                     is_long_op;
        logic                     is_rel_jump;
        logic [ADDR_W-1:0]        decoded_address;
        logic signed [DDIST_W-1:0] decoded_distance;
        logic [CODE_W-1:0]        code_word;
    } result_t;

    // sign-extend from bit lg-1 of a 13 bit value (lg in 1..13)
    function automatic logic [DDIST_W-1:0] wrap13(input logic [DDIST_W-1:0] v,
                                                  input logic [FSL_W-1:0] lg);
        logic [DDIST_W-1:0] r;
        logic               sgn;
        sgn = v[lg[3:0] - 4'd1];
        for (int i = 0; i < DDIST_W; i++)
        begin
            r[i] = (i < int'(lg)) ? v[i] : sgn;
        end
        return r;
    endfunction

endpackage

>>> hdl/bocu_regs.sv
// ----------------------------------------------------------------------------
// bocu_regs
// apb register file holding the flash size and address layout mode
// ----------------------------------------------------------------------------
module bocu_regs
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output bocu_pkg::cfg_t     cfg
);

    logic [bocu_pkg::FSL_W-1:0] fsl_reg;
    logic [bocu_pkg::AM_W-1:0]  am_reg;
    logic                       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsl_reg <= bocu_pkg::FSL_RESET;
            am_reg  <= bocu_pkg::AM_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                bocu_pkg::REG_FLASH_SIZE_LOG2: fsl_reg <= pwdata[bocu_pkg::FSL_W-1:0];
                bocu_pkg::REG_ADDRESS_MODE:    am_reg  <= pwdata[bocu_pkg::AM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            bocu_pkg::REG_FLASH_SIZE_LOG2: prdata[bocu_pkg::FSL_W-1:0] = fsl_reg;
            bocu_pkg::REG_ADDRESS_MODE:    prdata[bocu_pkg::AM_W-1:0]  = am_reg;
            default: prdata = '0;
        endcase
    end

    assign cfg.flash_size_log2 = fsl_reg;
    assign cfg.address_mode    = am_reg;

endmodule

>>> hdl/bocu_datapath.sv
// ----------------------------------------------------------------------------
// bocu_datapath
// combinational encode, decode and classify of one branch instruction
// ----------------------------------------------------------------------------
module bocu_datapath
(
    input  bocu_pkg::cfg_t                      cfg,
    input  logic [bocu_pkg::OP_W-1:0]           op,
    input  logic [bocu_pkg::INSTR_W-1:0]        instr,
    input  logic signed [bocu_pkg::DIST_W-1:0]  byte_distance,
    input  logic [bocu_pkg::ADDR_W-1:0]         byte_address,
    output bocu_pkg::result_t                   res
);

    logic [bocu_pkg::FSL_W-1:0]   lg;
    logic                         mode_ge1;
    logic                         mode_ge2;
    logic [15:0]                  w;
    logic [bocu_pkg::DDIST_W-1:0] rel_dec_raw;
    logic [bocu_pkg::DDIST_W-1:0] rel_dec;
    logic [bocu_pkg::DDIST_W-1:0] rel_enc_wrap;
    logic [11:0]                  rel_enc_off;
    logic                         abs_hit;
    logic                         call_hit;

    // wrap exponent clamped to 1..13
    always_comb
    begin
        if (cfg.flash_size_log2 > bocu_pkg::WRAP_LG_MAX)
            lg = bocu_pkg::WRAP_LG_MAX;
        else if (cfg.flash_size_log2 < bocu_pkg::WRAP_LG_MIN)
            lg = bocu_pkg::WRAP_LG_MIN;
        else
            lg = cfg.flash_size_log2;
    end

    // mode three acts as mode two
    assign mode_ge1 = (cfg.address_mode != 2'd0);
    assign mode_ge2 = cfg.address_mode[1];
    assign w        = instr[15:0];

    // rjmp decode: word offset to bytes, plus the pc increment
    assign rel_dec_raw = {w[11:0], 1'b0} + 13'd2;
    assign rel_dec     = bocu_pkg::wrap13(rel_dec_raw, lg);

    // rjmp encode: wrap the distance, back to words, minus the pc increment
    assign rel_enc_wrap = bocu_pkg::wrap13(byte_distance[bocu_pkg::DDIST_W-1:0], lg);
    assign rel_enc_off  = rel_enc_wrap[12:1] - 12'd1;

    assign abs_hit  = mode_ge1 ? ((w & bocu_pkg::LONGJ_MASK) == bocu_pkg::JMP_BASE)
                               : (w == bocu_pkg::JMP_BASE);
    assign call_hit = mode_ge1 ? ((w & bocu_pkg::LONGJ_MASK) == bocu_pkg::CALL_BASE)
                               : (w == bocu_pkg::CALL_BASE);

    always_comb
    begin
        res = '0;
        case (bocu_pkg::op_t'(op))
            bocu_pkg::OP_RJMP_DEC:
            begin
                res.decoded_distance = rel_dec;
            end
            bocu_pkg::OP_RJMP_ENC:
            begin
                res.code_word = {16'h0000, bocu_pkg::RJMP_BASE | {4'h0, rel_enc_off}};
            end
            bocu_pkg::OP_JMP_ENC:
            begin
                res.code_word = {byte_address[16:1], bocu_pkg::JMP_BASE};
                res.code_word[0]   = mode_ge1 & byte_address[17];
                res.code_word[8:4] = mode_ge2 ? byte_address[22:18] : 5'd0;
            end
            bocu_pkg::OP_JMP_DEC:
            begin
                res.decoded_address = {(mode_ge2 ? instr[8:4] : 5'd0),
                                       mode_ge1 & instr[0],
                                       instr[31:16], 1'b0};
            end
            bocu_pkg::OP_CLASSIFY:
            begin
                res.is_rel_jump = ((w & bocu_pkg::RJMP_MASK) == bocu_pkg::RJMP_BASE);
                res.is_abs_jump = abs_hit;
                res.is_long_op  = abs_hit | call_hit
                                | ((w & bocu_pkg::LDST_MASK) == bocu_pkg::STS_BASE)
                                | ((w & bocu_pkg::LDST_MASK) == bocu_pkg::LDS_BASE);
            end
            default: res = '0;
        endcase
    end

endmodule

>>> hdl/branch_opcode_codec_unit.sv
// ----------------------------------------------------------------------------
// branch_opcode_codec_unit
// stream codec for relative and absolute jump instructions
// ----------------------------------------------------------------------------
// Each input transaction selects one operation on tuser: decode an rjmp word
// into a wrapped byte distance, encode a byte distance as an rjmp word,
// encode a flash byte address as a 32-bit jmp, decode a jmp back to a byte
// address, or classify the low instruction word. Every input transaction
// yields exactly one output transaction; fields the operation does not
// produce, and every field of an unknown operation, are zero. An item passes
// through an input register, one level of decode logic and a result
// register. One item can enter every cycle while m_axis_tready does not hold
// a result back; the input register also takes a new item while a result
// waits on m_axis_tready, but only when it is itself empty. The apb registers
// (flash_size_log2 at 0x0, address_mode at 0x4) should be written only while
// no transaction is in flight.
module branch_opcode_codec_unit
(
    input  logic        clk,
    input  logic        rst_n,

    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] instr, [47:32] byte_distance, [70:48] byte_address, [71] zero
    input  logic [71:0] s_axis_tdata,
    // [2:0] op
    input  logic [2:0]  s_axis_tuser,

    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] code_word, [44:32] decoded_distance, [67:45] decoded_address,
    // [68] is_rel_jump, [69] is_long_op, [70] is_abs_jump, [71] zero
    output logic [71:0] m_axis_tdata,

    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    bocu_pkg::cfg_t    cfg;
    bocu_pkg::result_t res;

    // input register
    logic                                in_valid_reg;
    logic [bocu_pkg::OP_W-1:0]           op_reg;
    logic [bocu_pkg::INSTR_W-1:0]        instr_reg;
    logic signed [bocu_pkg::DIST_W-1:0]  dist_reg;
    logic [bocu_pkg::ADDR_W-1:0]         addr_reg;

    // result register
    logic                                out_valid_reg;
    bocu_pkg::result_t                   res_reg;

    logic in_take;
    logic out_load;

    // the result register frees up when empty or when its transaction leaves
    assign out_load      = !out_valid_reg || m_axis_tready;
    // the input register frees up when empty or when it moves forward
    assign s_axis_tready = !in_valid_reg || out_load;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    bocu_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bocu_datapath u_datapath
    (
        .cfg           (cfg),
        .op            (op_reg),
        .instr         (instr_reg),
        .byte_distance (dist_reg),
        .byte_address  (addr_reg),
        .res           (res)
    );

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (out_load)
                out_valid_reg <= in_valid_reg;
        end
    end

    // input payload, loaded on each accepted transaction
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg    <= s_axis_tuser;
            instr_reg <= s_axis_tdata[31:0];
            dist_reg  <= s_axis_tdata[47:32];
            addr_reg  <= s_axis_tdata[70:48];
        end
    end

    // result payload, loaded as the item moves into the result register
    always_ff @(posedge clk)
    begin
        if (out_load && in_valid_reg)
            res_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, res_reg};

endmodule

>>> hdl/bocu_chk.sv
// ----------------------------------------------------------------------------
// bocu_chk
// port-level checks for the branch opcode codec unit, bound to the top level
// ----------------------------------------------------------------------------
module bocu_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata
);

    // a stalled output transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output transaction changed while stalled");

    // the input side only stalls while a result waits downstream
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");

    // an item entering while the output is empty shows up after the input and result registers
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |=> ##1 m_axis_tvalid)
        else $error("accepted transaction did not reach output");

    // a result carries the fields of one operation only
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($countones({(m_axis_tdata[31:0] != 32'd0),
                                       (m_axis_tdata[44:32] != 13'd0),
                                       (m_axis_tdata[67:45] != 23'd0),
                                       (m_axis_tdata[70:68] != 3'd0)}) <= 1))
        else $error("result mixes fields of several operations");

    // the absolute jump flag implies the long instruction flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[70]) |-> m_axis_tdata[69])
        else $error("absolute jump not flagged as long instruction");

endmodule

bind branch_opcode_codec_unit bocu_chk u_bocu_chk
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// stream and apb testbench for the branch opcode codec unit
// ----------------------------------------------------------------------------
// A directed table (field extremes, every operation, opcode classes, unused
// operations) runs first in each configuration phase. Seeded random
// transactions follow, mostly well-formed rjmp, jump, call, sts and lds words.
// Every output transaction is checked field by field against an in-order
// queue. Each entry is either a value typed into the table or the result of
// a local branch codec predictor. Both stream sides idle at random, except
// in one calm phase.
// ----------------------------------------------------------------------------
module testbench;

    localparam real         HALF_PERIOD      = 2.0;
    localparam int unsigned RESET_CYCLES     = 7;
    localparam int unsigned PIPE_LATENCY     = 2;
    localparam int unsigned DRAIN_CYCLES     = 8;
    localparam int unsigned CYCLE_LIMIT      = 200000;
    localparam int unsigned MAX_REPORTS      = 10;
    localparam int unsigned IDLE_PERCENT     = 10;
    localparam int unsigned NUM_ROWS         = 24;
    localparam int unsigned NUM_PHASES       = 9;
    localparam int unsigned CALM_PHASE       = 4;
    localparam int unsigned RANDOM_PER_PHASE = 60;

    // tuser codes beyond the defined operations
    localparam logic [bocu_pkg::OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [bocu_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;

    // one row of the directed table; flags are {is_abs_jump, is_long_op, is_rel_jump}
    typedef struct {
        logic [bocu_pkg::OP_W-1:0]    op;
        logic [bocu_pkg::INSTR_W-1:0] instr;
        logic [bocu_pkg::DIST_W-1:0]  bdist;
        logic [bocu_pkg::ADDR_W-1:0]  addr;
        bit                           typed;
        logic [bocu_pkg::CODE_W-1:0]  code;
        logic [bocu_pkg::DDIST_W-1:0] ddist;
        logic [bocu_pkg::ADDR_W-1:0]  daddr;
        logic [2:0]                   flags;
    } branch_row_t;

    // expected values are typed in only for the reset configuration
    branch_row_t directed_rows [NUM_ROWS] = '{
        // rjmp decode: zero offset, -1 word, most negative, most positive
        '{bocu_pkg::OP_RJMP_DEC, 32'h0000_c000, 16'h0000, 23'h000000, 1'b1,
          32'h0, 13'h0002, 23'h0, 3'b000},
        '{bocu_pkg::OP_RJMP_DEC, 32'hffff_cfff, 16'h0000, 23'h000000, 1'b1,
          32'h0, 13'h0000, 23'h0, 3'b000},
        '{bocu_pkg::OP_RJMP_DEC, 32'h0000_c800, 16'h0000, 23'h000000, 1'b1,
          32'h0, 13'h1002, 23'h0, 3'b000},
        '{bocu_pkg::OP_RJMP_DEC, 32'h0000_c7ff, 16'h0000, 23'h000000, 1'b1,
          32'h0, 13'h1000, 23'h0, 3'b000},
        // rjmp encode: zero, one word, extremes of the distance field, minus one word
        '{bocu_pkg::OP_RJMP_ENC, 32'h0000_0000, 16'h0000, 23'h000000, 1'b1,
          32'h0000_cfff, 13'h0, 23'h0, 3'b000},
        '{bocu_pkg::OP_RJMP_ENC, 32'h0000_0000, 16'h0002, 23'h000000, 1'b1,
          32'h0000_c000, 13'h0, 23'h0, 3'b000},
        '{bocu_pkg::OP_RJMP_ENC, 32'hffff_ffff, 16'h7fff, 23'h7fffff, 1'b0,
          32'h0, 13'h0, 23'h0, 3'b000},
        '{bocu_pkg::OP_RJMP_ENC, 32'h0000_0000, 16'h8000, 23'h000000, 1'b0,
          32'h0, 13'h0, 23'h0, 3'b000},
        '{bocu_pkg::OP_RJMP_ENC, 32'h0000_0000, 16'hfffe, 23'h000000, 1'b0,
          32'h0, 13'h0, 23'h0, 3'b000},
        // jmp encode: zero, all ones, the 128k boundary bit alone
        '{bocu_pkg::OP_JMP_ENC, 32'h0000_0000, 16'h0000, 23'h000000, 1'b1,
          32'h0000_940c, 13'h0, 23'h0, 3'b000},
        '{bocu_pkg::OP_JMP_ENC, 32'hffff_ffff, 16'hffff, 23'h7fffff, 1'b0,
          32'h0, 13'h0, 23'h0, 3'b000},
        '{bocu_pkg::OP_JMP_ENC, 32'h0000_0000, 16'h0000, 23'h020000, 1'b0,
          32'h0, 13'h0, 23'h0, 3'b000},
        // jmp decode: zero, all ones, mixed address bits
        '{bocu_pkg::OP_JMP_DEC, 32'h0000_0000, 16'h0000, 23'h000000, 1'b1,
          32'h0, 13'h0, 23'h0, 3'b000},
        '{bocu_pkg::OP_JMP_DEC, 32'hffff_ffff, 16'h0000, 23'h000000, 1'b0,
          32'h0, 13'h0, 23'h0, 3'b000},
        '{bocu_pkg::OP_JMP_DEC, 32'h1234_0111, 16'h0000, 23'h000000, 1'b0,
          32'h0, 13'h0, 23'h0, 3'b000},
        // classify: exact jmp, call, sts, lds, rjmp
        '{bocu_pkg::OP_CLASSIFY, 32'h0000_940c, 16'h0000, 23'h000000, 1'b1,
          32'h0, 13'h0, 23'h0, 3'b110},
        '{bocu_pkg::OP_CLASSIFY, 32'h0000_940e, 16'h0000, 23'h000000, 1'b1,
          32'h0, 13'h0, 23'h0, 3'b010},
        '{bocu_pkg::OP_CLASSIFY, 32'h0000_9200, 16'h0000, 23'h000000, 1'b1,
          32'h0, 13'h0, 23'h0, 3'b010},
        '{bocu_pkg::OP_CLASSIFY, 32'h0000_9000, 16'h0000, 23'h000000, 1'b1,
          32'h0, 13'h0, 23'h0, 3'b010},
        '{bocu_pkg::OP_CLASSIFY, 32'h0000_c123, 16'h0000, 23'h000000, 1'b1,
          32'h0, 13'h0, 23'h0, 3'b001},
        // jmp with address bits set (only matched outside mode zero), then an all-ones word
        '{bocu_pkg::OP_CLASSIFY, 32'h0000_95fd, 16'h0000, 23'h000000, 1'b0,
          32'h0, 13'h0, 23'h0, 3'b000},
        '{bocu_pkg::OP_CLASSIFY, 32'h0000_ffff, 16'h0000, 23'h000000, 1'b1,
          32'h0, 13'h0, 23'h0, 3'b000},
        // unused operations give an all-zero result
        '{OP_SPARE_LO, 32'hffff_ffff, 16'hffff, 23'h7fffff, 1'b1,
          32'h0, 13'h0, 23'h0, 3'b000},
        '{OP_SPARE_HI, 32'hffff_ffff, 16'hffff, 23'h7fffff, 1'b1,
          32'h0, 13'h0, 23'h0, 3'b000}
    };

    // register settings per phase; phase zero keeps the reset values
    logic [bocu_pkg::FSL_W-1:0] fsl_plan [NUM_PHASES] = '{5'd15, 5'd0, 5'd1, 5'd13, 5'd31,
                                                          5'd10, 5'd23, 5'd12, 5'd7};
    logic [bocu_pkg::AM_W-1:0]  am_plan  [NUM_PHASES] = '{2'd2, 2'd0, 2'd1, 2'd3, 2'd2,
                                                          2'd0, 2'd1, 2'd3, 2'd2};

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    // [31:0] instr, [47:32] byte_distance, [70:48] byte_address, [71] zero
    logic [bocu_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    // [2:0] op
    logic [bocu_pkg::OP_W-1:0]       s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // [31:0] code_word, [44:32] decoded_distance, [67:45] decoded_address,
    // [68] is_rel_jump, [69] is_long_op, [70] is_abs_jump, [71] zero
    logic [bocu_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [2:0]                      paddr = '0;
    logic [31:0]                     pwdata = '0;
    logic [31:0]                     prdata;
    logic                            pready;

    // local copy of the register file, kept in step with every apb write
    logic [bocu_pkg::FSL_W-1:0]      cfg_fsl = bocu_pkg::FSL_RESET;
    logic [bocu_pkg::AM_W-1:0]       cfg_am  = bocu_pkg::AM_RESET;

    // results still owed by the block, oldest first
    bocu_pkg::result_t               branch_expect_q [$];
    bit                              calm = 1'b0;
    int unsigned                     fault_count = 0;
    int unsigned                     cycle_count = 0;

    branch_opcode_codec_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // wrap a two's complement distance into [-span/2, span/2), span = 2^lg
    function automatic logic [31:0] wrap_distance(input logic [31:0] v);
        logic [bocu_pkg::FSL_W-1:0] lg;
        logic [31:0]                span;
        logic [31:0]                r;
        lg = cfg_fsl;
        if (lg > bocu_pkg::WRAP_LG_MAX)
            lg = bocu_pkg::WRAP_LG_MAX;
        if (lg < bocu_pkg::WRAP_LG_MIN)
            lg = bocu_pkg::WRAP_LG_MIN;
        span = 32'd1 << lg;
        r = v & (span - 32'd1);
        if (r >= (span >> 1))
            r = r - span;
        return r;
    endfunction

    // expected result of one transaction under the current register copy
    function automatic bocu_pkg::result_t predict_branch_result(
        input logic [bocu_pkg::OP_W-1:0]    op,
        input logic [bocu_pkg::INSTR_W-1:0] instr,
        input logic [bocu_pkg::DIST_W-1:0]  bdist,
        input logic [bocu_pkg::ADDR_W-1:0]  addr);
        bocu_pkg::result_t r;
        logic [1:0]        mode;
        logic [15:0]       w;
        logic [31:0]       v;
        logic [31:0]       a;
        logic              jmp_hit;
        logic              call_hit;
        r = '0;
        // mode three decodes like mode two
        mode = (cfg_am > 2'd2) ? 2'd2 : cfg_am;
        w = instr[15:0];
        case (op)
            bocu_pkg::OP_RJMP_DEC:
            begin
                // word offset to byte offset, plus the skip of the rjmp itself
                v = wrap_distance({{19{w[11]}}, w[11:0], 1'b0} + 32'd2);
                r.decoded_distance = v[bocu_pkg::DDIST_W-1:0];
            end
            bocu_pkg::OP_RJMP_ENC:
            begin
                v = wrap_distance({{16{bdist[15]}}, bdist});
                v = (v >> 1) - 32'd1;
                r.code_word = {16'd0, bocu_pkg::RJMP_BASE | {4'd0, v[11:0]}};
            end
            bocu_pkg::OP_JMP_ENC:
            begin
                r.code_word = {addr[16:1], bocu_pkg::JMP_BASE};
                if (mode >= 2'd1)
                    r.code_word[0] = r.code_word[0] | addr[17];
                if (mode >= 2'd2)
                    r.code_word[8:4] = r.code_word[8:4] | addr[22:18];
            end
            bocu_pkg::OP_JMP_DEC:
            begin
                a = {16'd0, instr[31:16]};
                if (mode >= 2'd1)
                    a[16] = instr[0];
                if (mode >= 2'd2)
                    a[21:17] = instr[8:4];
                r.decoded_address = {a[21:0], 1'b0};
            end
            bocu_pkg::OP_CLASSIFY:
            begin
                // mode zero compares jmp and call words exactly
                if (mode == 2'd0)
                begin
                    jmp_hit  = (w == bocu_pkg::JMP_BASE);
                    call_hit = (w == bocu_pkg::CALL_BASE);
                end
                else
                begin
                    jmp_hit  = ((w & bocu_pkg::LONGJ_MASK) == bocu_pkg::JMP_BASE);
                    call_hit = ((w & bocu_pkg::LONGJ_MASK) == bocu_pkg::CALL_BASE);
                end
                r.is_rel_jump = ((w & bocu_pkg::RJMP_MASK) == bocu_pkg::RJMP_BASE);
                r.is_abs_jump = jmp_hit;
                r.is_long_op  = jmp_hit || call_hit ||
                                ((w & bocu_pkg::LDST_MASK) == bocu_pkg::STS_BASE) ||
                                ((w & bocu_pkg::LDST_MASK) == bocu_pkg::LDS_BASE);
            end
            default:
                r = '0;
        endcase
        return r;
    endfunction

    // offer one transaction, with random idle cycles ahead of it
    task automatic send_branch_item(input logic [bocu_pkg::OP_W-1:0]    op,
                                    input logic [bocu_pkg::INSTR_W-1:0] instr,
                                    input logic [bocu_pkg::DIST_W-1:0]  bdist,
                                    input logic [bocu_pkg::ADDR_W-1:0]  addr,
                                    input bit                           typed,
                                    input bocu_pkg::result_t            want);
        while (!calm && ($urandom_range(0, 99) < IDLE_PERCENT))
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {1'b0, addr, bdist, instr};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        // accepted at this edge
        if (typed)
            branch_expect_q.push_back(want);
        else
            branch_expect_q.push_back(predict_branch_result(op, instr, bdist, addr));
    endtask

    // apb write, setup then access, then back to idle
    task automatic write_register(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == bocu_pkg::REG_FLASH_SIZE_LOG2)
            cfg_fsl = value[bocu_pkg::FSL_W-1:0];
        else
            cfg_am = value[bocu_pkg::AM_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // apb read compared with the local register copy
    task automatic check_register(input logic idx, input logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== want)
        begin
            if (fault_count < MAX_REPORTS)
                $display("register %0d read: expected %h, got %h", idx, want, prdata);
            fault_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // wait until every owed result is back, then let the pipeline empty
    task automatic settle_pipeline();
        while (branch_expect_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 2)
            @(posedge clk);
    endtask

    // output side: random back-pressure and in-order result check
    always @(posedge clk)
    begin : watch_results
        bocu_pkg::result_t got;
        bocu_pkg::result_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[$bits(bocu_pkg::result_t)-1:0];
                if (branch_expect_q.size() == 0)
                begin
                    if (fault_count < MAX_REPORTS)
                        $display("unexpected output transaction: %h", m_axis_tdata);
                    fault_count++;
                end
                else
                begin
                    want = branch_expect_q.pop_front();
                    if (got.code_word !== want.code_word ||
                        got.decoded_distance !== want.decoded_distance ||
                        got.decoded_address !== want.decoded_address ||
                        got.is_rel_jump !== want.is_rel_jump ||
                        got.is_long_op !== want.is_long_op ||
                        got.is_abs_jump !== want.is_abs_jump)
                    begin
                        if (fault_count < MAX_REPORTS)
                        begin
                            $display("exp code %h dist %h addr %h rel %b long %b abs %b",
                                     want.code_word, want.decoded_distance,
                                     want.decoded_address, want.is_rel_jump,
                                     want.is_long_op, want.is_abs_jump);
                            $display("got code %h dist %h addr %h rel %b long %b abs %b",
                                     got.code_word, got.decoded_distance,
                                     got.decoded_address, got.is_rel_jump,
                                     got.is_long_op, got.is_abs_jump);
                        end
                        fault_count++;
                    end
                end
            end
            m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        logic [bocu_pkg::OP_W-1:0]    op;
        logic [bocu_pkg::INSTR_W-1:0] instr;
        logic [bocu_pkg::DIST_W-1:0]  bdist;
        logic [bocu_pkg::ADDR_W-1:0]  addr;
        logic [15:0]                  lo;
        logic [31:0]                  rnd;
        bocu_pkg::result_t            want;
        bit                           typed;
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            // registers change only with nothing in flight
            if (ph != 0)
            begin
                settle_pipeline();
                write_register(bocu_pkg::REG_FLASH_SIZE_LOG2, 32'(fsl_plan[ph]));
                write_register(bocu_pkg::REG_ADDRESS_MODE, 32'(am_plan[ph]));
            end
            check_register(bocu_pkg::REG_FLASH_SIZE_LOG2, 32'(cfg_fsl));
            check_register(bocu_pkg::REG_ADDRESS_MODE, 32'(cfg_am));
            calm = (ph == CALM_PHASE);

            // directed table
            for (int k = 0; k < NUM_ROWS; k++)
            begin
                typed = directed_rows[k].typed && (cfg_fsl == bocu_pkg::FSL_RESET) &&
                        (cfg_am == bocu_pkg::AM_RESET);
                want = '0;
                want.code_word        = directed_rows[k].code;
                want.decoded_distance = directed_rows[k].ddist;
                want.decoded_address  = directed_rows[k].daddr;
                {want.is_abs_jump, want.is_long_op, want.is_rel_jump} =
                    directed_rows[k].flags;
                send_branch_item(directed_rows[k].op, directed_rows[k].instr,
                                 directed_rows[k].bdist, directed_rows[k].addr,
                                 typed, want);
            end

            // random transactions, mostly well-formed opcode words
            for (int k = 0; k < RANDOM_PER_PHASE; k++)
            begin
                if ($urandom_range(0, 99) < 94)
                    rnd = $urandom_range(32'(bocu_pkg::OP_RJMP_DEC),
                                         32'(bocu_pkg::OP_CLASSIFY));
                else
                    rnd = $urandom_range(32'(OP_SPARE_LO), 32'(OP_SPARE_HI));
                op = rnd[bocu_pkg::OP_W-1:0];
                instr = $urandom;
                lo = instr[15:0];
                case ($urandom_range(0, 7))
                    0: lo = bocu_pkg::RJMP_BASE | (lo & ~bocu_pkg::RJMP_MASK);
                    1: lo = bocu_pkg::JMP_BASE | (lo & ~bocu_pkg::LONGJ_MASK);
                    2: lo = bocu_pkg::CALL_BASE | (lo & ~bocu_pkg::LONGJ_MASK);
                    3: lo = bocu_pkg::STS_BASE | (lo & ~bocu_pkg::LDST_MASK);
                    4: lo = bocu_pkg::LDS_BASE | (lo & ~bocu_pkg::LDST_MASK);
                    5: lo = bocu_pkg::JMP_BASE;
                    6: lo = bocu_pkg::CALL_BASE;
                    default: ;
                endcase
                instr[15:0] = lo;
                // short distances around zero now and then, else the full range
                if ($urandom_range(0, 3) == 0)
                    rnd = $urandom_range(0, 31) - 32'd16;
                else
                    rnd = $urandom;
                bdist = rnd[bocu_pkg::DIST_W-1:0];
                rnd = $urandom;
                addr = rnd[bocu_pkg::ADDR_W-1:0];
                send_branch_item(op, instr, bdist, addr, 1'b0, '0);
            end
            s_axis_tvalid <= 1'b0;
        end

        while (branch_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (fault_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> branch_opcode_codec_unit.f
hdl/bocu_pkg.sv
hdl/bocu_regs.sv
hdl/bocu_datapath.sv
hdl/branch_opcode_codec_unit.sv
hdl/bocu_chk.sv
tb/testbench.sv
